@@ rtl/dbsb_pkg.sv @@
// ----------------------------------------------------------------------------
// dbsb_pkg
// Shared widths, codes and defaults for the stream-bypass RRIP replacement.
// ----------------------------------------------------------------------------
package dbsb_pkg;

  localparam int DEF_NUM_SETS       = 2048;
  localparam int DEF_NUM_WAYS       = 16;
  localparam int DEF_DECAY_INTERVAL = 4096;
  localparam int DEF_LEADER_COUNT   = 32;

  localparam int SET_W   = 11;
  localparam int WAY_W   = 4;
  localparam int ADDR_W  = 64;
  localparam int DRAW_W  = 5;
  localparam int DELTA_W = 16;
  localparam int RRPV_W  = 2;
  localparam int CONF_W  = 2;
  localparam int SEL_W   = 10;

  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;

  localparam logic [CONF_W-1:0] CONF_MAX    = 2'd3;
  localparam logic [CONF_W-1:0] CONF_STREAM = 2'd2;

  localparam logic [SEL_W-1:0] SEL_MAX = 10'd1023;
  localparam logic [SEL_W-1:0] SEL_MID = 10'd512;

  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

endpackage

@@ rtl/dbsb_if.sv @@
// ----------------------------------------------------------------------------
// dbsb_if
// Request and response channels of the replacement block.
// ----------------------------------------------------------------------------
interface dbsb_req_if import dbsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SET_W-1:0]  set_index;
  logic [WAY_W-1:0]  way_index;
  logic [ADDR_W-1:0] phys_address;
  logic              was_hit;
  logic [DRAW_W-1:0] random_draw;

  modport source (output valid, kind, set_index, way_index, phys_address, was_hit,
                  random_draw, input ready);
  modport sink (input valid, kind, set_index, way_index, phys_address, was_hit,
                random_draw, output ready);
endinterface

interface dbsb_rsp_if import dbsb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WAY_W-1:0] victim_way;
  logic             streaming_seen;

  modport source (output valid, victim_way, streaming_seen, input ready);
  modport sink (input valid, victim_way, streaming_seen, output ready);
endinterface

@@ rtl/dbsb_age_unit.sv @@
// ----------------------------------------------------------------------------
// dbsb_age_unit
// One aging step over a set row: finds the first distant way, or ages all.
// ----------------------------------------------------------------------------
module dbsb_age_unit import dbsb_pkg::*; #(
  parameter int NUM_WAYS = DEF_NUM_WAYS
) (
  input  logic [NUM_WAYS*RRPV_W-1:0]  row,
  output logic                        has_max,
  output logic [$clog2(NUM_WAYS)-1:0] first_way,
  output logic [NUM_WAYS*RRPV_W-1:0]  aged
);

  localparam int WW = $clog2(NUM_WAYS);

  always_comb begin
    has_max   = 1'b0;
    first_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[w*RRPV_W +: RRPV_W] == RRPV_MAX) begin
        has_max   = 1'b1;
        first_way = WW'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w*RRPV_W +: RRPV_W] = row[w*RRPV_W +: RRPV_W] + RRPV_W'(1);
    end
  end

endmodule

@@ rtl/drrip_dead_block_stream_bypass.sv @@
// ----------------------------------------------------------------------------
// drrip_dead_block_stream_bypass
// Set-dueling RRIP replacement with decaying reuse bits and stride bypass.
// ----------------------------------------------------------------------------
// channel  dir  beat
// req      in   kind, set_index, way_index, phys_address, was_hit, random_draw
// rsp      out  victim_way, streaming_seen
//
// Update: accept, set reduction if out of range, row read, compute, write back.
// Victim: accept, row read, then one aging pass a cycle through the age unit until a way is distant.
// Every DECAY_INTERVAL updates a reuse sweep clears the reuse bits of all sets.
// After reset a clearing pass over all sets runs before req.ready rises.
// A held response stalls write back of the next beat until the output register frees.
// ----------------------------------------------------------------------------
module drrip_dead_block_stream_bypass import dbsb_pkg::*; #(
  parameter int NUM_SETS       = DEF_NUM_SETS,
  parameter int NUM_WAYS       = DEF_NUM_WAYS,
  parameter int DECAY_INTERVAL = DEF_DECAY_INTERVAL,
  parameter int LEADER_COUNT   = DEF_LEADER_COUNT
) (
  input logic        clk,
  input logic        rst,
  dbsb_req_if.sink   req,
  dbsb_rsp_if.source rsp
);

  localparam int SW       = $clog2(NUM_SETS);
  localparam int RW       = (SW > SET_W) ? SW : SET_W;
  localparam int CW       = RW + 1;
  localparam int WW       = $clog2(NUM_WAYS);
  localparam int RV_W     = NUM_WAYS * RRPV_W;
  localparam int MAIN_W   = RV_W + CONF_W + DELTA_W + ADDR_W;
  localparam int DW       = $clog2(DECAY_INTERVAL);
  localparam int BRRIP_LO = (NUM_SETS > LEADER_COUNT) ? NUM_SETS - LEADER_COUNT : 0;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_REDUCE = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_AGE    = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;
  localparam logic [2:0] ST_SWEEP  = 3'd6;
  localparam logic [2:0] ST_WB     = 3'd7;

  logic [2:0]          state;
  logic [SW-1:0]       sweep;
  logic [RW-1:0]       red;
  logic                kind_r;
  logic [WAY_W-1:0]    way_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                hit_r;
  logic [DRAW_W-1:0]   draw_r;
  logic [RV_W-1:0]     w_rrpv;
  logic [NUM_WAYS-1:0] w_reuse;
  logic [CONF_W-1:0]   w_conf;
  logic [DELTA_W-1:0]  w_delta;
  logic [ADDR_W-1:0]   w_addr;
  logic                stream_r;
  logic [SEL_W-1:0]    sel;
  logic [DW-1:0]       dcnt;
  logic                o_valid;
  logic [WAY_W-1:0]    o_victim;
  logic                o_stream;

  logic [MAIN_W-1:0]   main_mem [NUM_SETS];
  logic [NUM_WAYS-1:0] reuse_mem [NUM_SETS];
  logic [MAIN_W-1:0]   main_rd;
  logic [NUM_WAYS-1:0] reuse_rd;

  logic                rd_en;
  logic [SW-1:0]       rd_addr;
  logic                main_we;
  logic                reuse_we;
  logic [SW-1:0]       wr_addr;
  logic [MAIN_W-1:0]   main_wd;
  logic [NUM_WAYS-1:0] reuse_wd;

  logic                req_in_rng;
  logic                in_rng;
  logic                srrip_ldr;
  logic                brrip_ldr;
  logic                o_free;
  logic                o_load;
  logic                sweep_last;

  logic                has_max;
  logic [WW-1:0]       first_way;
  logic [RV_W-1:0]     aged;

  logic [DELTA_W-1:0]  delta;
  logic                stride_hit;
  logic [CONF_W-1:0]   conf_next;
  logic                streaming;
  logic                decay_hit;
  logic [NUM_WAYS-1:0] reuse_eff;
  logic                way_ok;
  logic [WW-1:0]       wsel;
  logic                srrip_ins;
  logic [RRPV_W-1:0]   ins;
  logic [RV_W-1:0]     rrpv_upd;
  logic [NUM_WAYS-1:0] reuse_upd;
  logic [SEL_W-1:0]    sel_next;

  dbsb_age_unit #(
    .NUM_WAYS (NUM_WAYS)
  ) u_age (
    .row       (w_rrpv),
    .has_max   (has_max),
    .first_way (first_way),
    .aged      (aged)
  );

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = o_valid;
  assign rsp.victim_way     = o_victim;
  assign rsp.streaming_seen = o_stream;

  assign o_free     = !o_valid || rsp.ready;
  assign o_load     = o_free && (((state == ST_AGE) && has_max) || (state == ST_WB));
  assign req_in_rng = CW'(req.set_index) < CW'(NUM_SETS);
  assign in_rng     = CW'(red) < CW'(NUM_SETS);
  assign srrip_ldr  = CW'(red) < CW'(LEADER_COUNT);
  assign brrip_ldr  = !srrip_ldr && (CW'(red) >= CW'(BRRIP_LO));
  assign sweep_last = (sweep == SW'(NUM_SETS - 1));

  // stride detector, decay, insertion and selector update
  always_comb begin
    delta      = addr_r[DELTA_W-1:0] - w_addr[DELTA_W-1:0];
    stride_hit = (delta != '0) && (delta == w_delta);
    if (stride_hit) begin
      conf_next = (w_conf == CONF_MAX) ? w_conf : w_conf + CONF_W'(1);
    end else begin
      conf_next = (w_conf == '0) ? w_conf : w_conf - CONF_W'(1);
    end
    streaming = (conf_next >= CONF_STREAM);
    decay_hit = (dcnt == DW'(DECAY_INTERVAL - 1));
    reuse_eff = decay_hit ? '0 : w_reuse;
    way_ok    = {2'b00, way_r} < 6'(NUM_WAYS);
    wsel      = WW'(way_r);

    if (srrip_ldr) begin
      srrip_ins = 1'b1;
    end else if (brrip_ldr) begin
      srrip_ins = 1'b0;
    end else begin
      srrip_ins = (sel >= SEL_MID);
    end

    if (streaming || !reuse_eff[wsel]) begin
      ins = RRPV_MAX;
    end else if (srrip_ins) begin
      ins = RRPV_LONG;
    end else begin
      ins = (draw_r == '0) ? RRPV_NEAR : RRPV_LONG;
    end

    rrpv_upd  = w_rrpv;
    reuse_upd = reuse_eff;
    if (way_ok) begin
      if (hit_r) begin
        reuse_upd[wsel]                  = 1'b1;
        rrpv_upd[wsel*RRPV_W +: RRPV_W]  = RRPV_NEAR;
      end else begin
        reuse_upd[wsel]                  = 1'b0;
        rrpv_upd[wsel*RRPV_W +: RRPV_W]  = ins;
      end
    end

    sel_next = sel;
    if (hit_r && srrip_ldr && (sel != SEL_MAX)) begin
      sel_next = sel + SEL_W'(1);
    end else if (hit_r && brrip_ldr && (sel != '0)) begin
      sel_next = sel - SEL_W'(1);
    end
  end

  // memory port control
  always_comb begin
    rd_en    = ((state == ST_IDLE) && req.valid && req_in_rng) ||
               ((state == ST_REDUCE) && in_rng);
    rd_addr  = (state == ST_IDLE) ? SW'(req.set_index) : red[SW-1:0];
    main_we  = (state == ST_CLEAR) ||
               ((state == ST_AGE) && has_max && o_free) ||
               ((state == ST_WB) && o_free);
    reuse_we = (state == ST_CLEAR) || (state == ST_SWEEP) ||
               ((state == ST_WB) && o_free);
    wr_addr  = ((state == ST_CLEAR) || (state == ST_SWEEP)) ? sweep : red[SW-1:0];
    if (state == ST_CLEAR) begin
      main_wd = {{NUM_WAYS{RRPV_MAX}}, (MAIN_W - RV_W)'(0)};
    end else begin
      main_wd = {w_rrpv, w_conf, w_delta, w_addr};
    end
    reuse_wd = ((state == ST_CLEAR) || (state == ST_SWEEP)) ? '0 : w_reuse;
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[wr_addr] <= main_wd;
    end
    if (reuse_we) begin
      reuse_mem[wr_addr] <= reuse_wd;
    end
    if (rd_en) begin
      main_rd  <= main_mem[rd_addr];
      reuse_rd <= reuse_mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      sweep   <= '0;
      sel     <= SEL_MID;
      dcnt    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (sweep_last) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + SW'(1);
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            kind_r <= req.kind;
            red    <= RW'(req.set_index);
            way_r  <= req.way_index;
            addr_r <= req.phys_address;
            hit_r  <= req.was_hit;
            draw_r <= req.random_draw;
            state  <= req_in_rng ? ST_LOAD : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (in_rng) begin
            state <= ST_LOAD;
          end else begin
            red <= red - RW'(NUM_SETS);
          end
        end
        ST_LOAD: begin
          w_rrpv  <= main_rd[MAIN_W-1 -: RV_W];
          w_conf  <= main_rd[ADDR_W+DELTA_W +: CONF_W];
          w_delta <= main_rd[ADDR_W +: DELTA_W];
          w_addr  <= main_rd[ADDR_W-1:0];
          w_reuse <= reuse_rd;
          state   <= (kind_r == KIND_VICTIM) ? ST_AGE : ST_UPD;
        end
        ST_AGE: begin
          if (has_max) begin
            if (o_free) begin
              o_victim <= WAY_W'(first_way);
              o_stream <= 1'b0;
              state    <= ST_IDLE;
            end
          end else begin
            w_rrpv <= aged;
          end
        end
        ST_UPD: begin
          w_rrpv   <= rrpv_upd;
          w_reuse  <= reuse_upd;
          w_conf   <= conf_next;
          w_delta  <= delta;
          w_addr   <= addr_r;
          stream_r <= streaming;
          sel      <= sel_next;
          dcnt     <= decay_hit ? '0 : dcnt + DW'(1);
          sweep    <= '0;
          state    <= decay_hit ? ST_SWEEP : ST_WB;
        end
        ST_SWEEP: begin
          if (sweep_last) begin
            sweep <= '0;
            state <= ST_WB;
          end else begin
            sweep <= sweep + SW'(1);
          end
        end
        ST_WB: begin
          if (o_free) begin
            o_victim <= '0;
            o_stream <= stream_r;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.streaming_seen |-> rsp.victim_way == '0)
    else $error("streaming flag on a victim beat");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second beat taken while busy");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req.ready)
    else $error("beat taken during clearing pass");

  a_sweep_wrapped: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> dcnt == '0)
    else $error("reuse sweep without decay wrap");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stream-bypass RRIP replacement block. Request
// beats go out in random bursts while the response side stalls on its own
// pattern. A behavioral copy of the policy state predicts every response,
// and each response is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb import dbsb_pkg::*; ();

  localparam int NSETS        = DEF_NUM_SETS;
  localparam int NWAYS        = DEF_NUM_WAYS;
  localparam int DECAY        = DEF_DECAY_INTERVAL;
  localparam int LEADERS      = DEF_LEADER_COUNT;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 20;

  typedef struct packed {
    logic              kind;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic [ADDR_W-1:0] phys_address;
    logic              was_hit;
    logic [DRAW_W-1:0] random_draw;
  } req_beat_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             streaming_seen;
  } rsp_beat_t;

  logic clk;
  logic rst;

  dbsb_req_if req_ch ();
  dbsb_rsp_if rsp_ch ();

  drrip_dead_block_stream_bypass i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // policy state mirror
  logic [RRPV_W-1:0]  age_m       [NSETS][NWAYS];
  logic [NWAYS-1:0]   reuse_m     [NSETS];
  logic [CONF_W-1:0]  conf_m      [NSETS];
  logic [ADDR_W-1:0]  last_addr_m [NSETS];
  logic [DELTA_W-1:0] last_delta_m[NSETS];
  logic [SEL_W-1:0]   sel_m;
  int                 decay_cnt_m;

  rsp_beat_t rrip_rsp_q[$];

  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int beats_sent   = 0;
  int victims_seen = 0;
  int stream_flags = 0;
  int decay_wraps  = 0;
  int sel_top_hits = 0;
  int sel_low_hits = 0;
  int burst_left   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, rrip_rsp_q.size());
    $display("FAIL drrip_dead_block_stream_bypass");
    $finish;
  end

  function automatic rsp_beat_t rrip_predict(input req_beat_t b);
    rsp_beat_t          o;
    int                 s;
    int                 w;
    logic [RRPV_W-1:0]  top;
    logic [DELTA_W-1:0] d;
    logic               srrip_set;
    logic               brrip_set;
    logic               srrip_ins;
    logic               streaming;
    o = '0;
    s = int'(b.set_index) % NSETS;
    w = int'(b.way_index);
    srrip_set = s < LEADERS;
    brrip_set = !srrip_set && s >= NSETS - LEADERS;
    if (b.kind == KIND_VICTIM) begin
      top = '0;
      for (int i = 0; i < NWAYS; i++) begin
        if (age_m[s][i] > top) top = age_m[s][i];
      end
      if (top != RRPV_MAX) begin
        for (int i = 0; i < NWAYS; i++) age_m[s][i] = age_m[s][i] + (RRPV_MAX - top);
      end
      for (int i = NWAYS - 1; i >= 0; i--) begin
        if (age_m[s][i] == RRPV_MAX) o.victim_way = WAY_W'(i);
      end
      victims_seen++;
      return o;
    end
    // stride training
    d = DELTA_W'(b.phys_address - last_addr_m[s]);
    if (d != '0 && d == last_delta_m[s]) begin
      if (conf_m[s] != CONF_MAX) conf_m[s]++;
    end else if (conf_m[s] != '0) begin
      conf_m[s]--;
    end
    last_delta_m[s] = d;
    last_addr_m[s]  = b.phys_address;
    streaming = conf_m[s] >= CONF_STREAM;
    decay_cnt_m++;
    if (decay_cnt_m >= DECAY) begin
      decay_cnt_m = 0;
      foreach (reuse_m[i]) reuse_m[i] = '0;
      decay_wraps++;
    end
    if (b.was_hit) begin
      if (w < NWAYS) begin
        reuse_m[s][w] = 1'b1;
        age_m[s][w]   = RRPV_NEAR;
      end
      if (srrip_set) begin
        if (sel_m != SEL_MAX) sel_m++;
        else sel_top_hits++;
      end else if (brrip_set) begin
        if (sel_m != '0) sel_m--;
        else sel_low_hits++;
      end
    end else if (w < NWAYS) begin
      srrip_ins = srrip_set || (!brrip_set && sel_m >= SEL_MID);
      if (streaming || !reuse_m[s][w]) age_m[s][w] = RRPV_MAX;
      else if (srrip_ins || b.random_draw != '0) age_m[s][w] = RRPV_LONG;
      else age_m[s][w] = RRPV_NEAR;
      reuse_m[s][w] = 1'b0;
    end
    o.streaming_seen = streaming;
    if (streaming) stream_flags++;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_req(input logic kind, input int set, input int way,
                          input logic [ADDR_W-1:0] addr, input logic hit,
                          input int draw, output rsp_beat_t r);
    req_beat_t b;
    int        gap;
    b.kind         = kind;
    b.set_index    = SET_W'(set);
    b.way_index    = WAY_W'(way);
    b.phys_address = addr;
    b.was_hit      = hit;
    b.random_draw  = DRAW_W'(draw);
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= b.kind;
    req_ch.set_index    <= b.set_index;
    req_ch.way_index    <= b.way_index;
    req_ch.phys_address <= b.phys_address;
    req_ch.was_hit      <= b.was_hit;
    req_ch.random_draw  <= b.random_draw;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = rrip_predict(b);
    rrip_rsp_q.push_back(r);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  // response side: ready pattern changes mode at random
  initial begin : rsp_pacer
    int mode;
    int span;
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            if (hold > 0) begin
              hold--;
              rsp_ch.ready <= 1'b0;
            end else begin
              rsp_ch.ready <= 1'b1;
              if ($urandom_range(0, 3) == 0) hold = $urandom_range(4, 12);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_beat_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rrip_rsp_q.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
      end else begin
        want = rrip_rsp_q.pop_front();
        if (rsp_ch.victim_way !== want.victim_way)
          report_mismatch($sformatf("victim_way got %0d want %0d",
                                    rsp_ch.victim_way, want.victim_way));
        if (rsp_ch.streaming_seen !== want.streaming_seen)
          report_mismatch($sformatf("streaming_seen got %0b want %0b",
                                    rsp_ch.streaming_seen, want.streaming_seen));
      end
    end
  end

  function automatic int pick_set();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, 2);
      2:       return $urandom_range(29, 33);
      3, 4:    return $urandom_range(NSETS - 3, NSETS - 1);
      5:       return $urandom_range(NSETS - 34, NSETS - 30);
      6, 7, 8: return $urandom_range(1000, 1003);
      default: return $urandom_range(0, NSETS - 1);
    endcase
  endfunction

  function automatic int pick_draw();
    return ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 31);
  endfunction

  // mostly strided per set so the stream detector climbs and falls
  function automatic logic [ADDR_W-1:0] next_addr(input int s);
    int                p;
    logic [ADDR_W-1:0] stride;
    p = $urandom_range(0, 99);
    stride = ADDR_W'(((s % 5) + 1) * 64);
    if ((s % 2) == 1) stride = -stride;
    if (p < 50) return last_addr_m[s] + stride;
    if (p < 60) return last_addr_m[s];
    if (p < 68) return last_addr_m[s] + 64'h10000;
    if (p < 80) return last_addr_m[s] + ADDR_W'($urandom_range(1, 255) * 8);
    return {$urandom, $urandom};
  endfunction

  task automatic random_access();
    rsp_beat_t r;
    int        s;
    int        pick;
    int        o;
    int        k;
    s = pick_set();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // miss: victim search, then fill the chosen way
      send_req(KIND_VICTIM, s, $urandom_range(0, NWAYS - 1), {$urandom, $urandom},
               1'($urandom_range(0, 1)), $urandom_range(0, 31), r);
      send_req(KIND_UPDATE, s, r.victim_way, next_addr(s), 1'b0, pick_draw(), r);
    end else if (pick < 77) begin
      send_req(KIND_UPDATE, s, $urandom_range(0, NWAYS - 1), next_addr(s), 1'b1,
               pick_draw(), r);
    end else if (pick < 85) begin
      // touch every way so the next search may have to age the set
      o = $urandom_range(0, NWAYS - 1);
      k = 2 * $urandom_range(0, NWAYS / 2 - 1) + 1;
      for (int i = 0; i < NWAYS; i++)
        send_req(KIND_UPDATE, s, (o + i * k) % NWAYS, next_addr(s),
                 $urandom_range(0, 4) != 0, pick_draw(), r);
      send_req(KIND_VICTIM, s, 0, '0, 1'b0, 0, r);
    end else begin
      send_req(1'($urandom_range(0, 1)), $urandom_range(0, NSETS - 1),
               $urandom_range(0, NWAYS - 1), {$urandom, $urandom},
               1'($urandom_range(0, 1)), $urandom_range(0, 31), r);
    end
  endtask

  task automatic test_directed();
    rsp_beat_t r;
    send_req(KIND_VICTIM, 0, 0, '0, 1'b0, 0, r);
    send_req(KIND_UPDATE, 0, NWAYS - 1, '0, 1'b1, 0, r);
    send_req(KIND_UPDATE, NSETS - 1, 0, '1, 1'b1, 31, r);
    // reused line, BRRIP leader, zero draw: near insert
    send_req(KIND_UPDATE, NSETS - 1, 0, '1, 1'b0, 0, r);
    send_req(KIND_VICTIM, NSETS - 1, NWAYS - 1, '1, 1'b1, 31, r);
    send_req(KIND_UPDATE, LEADERS - 1, 3, 64'h40, 1'b1, 5, r);
    send_req(KIND_UPDATE, LEADERS - 1, 3, 64'h80, 1'b0, 0, r);
    send_req(KIND_UPDATE, NSETS - LEADERS, 4, 64'h1000, 1'b1, 0, r);
    send_req(KIND_UPDATE, NSETS - LEADERS, 4, 64'h2000, 1'b0, 31, r);
    send_req(KIND_UPDATE, NSETS - LEADERS, 4, 64'h3000, 1'b0, 0, r);
    send_req(KIND_VICTIM, NSETS - LEADERS, 0, '0, 1'b0, 0, r);
    // follower stream: confidence climbs to 3, then a zero low delta
    send_req(KIND_UPDATE, 1000, 9, 64'h100, 1'b1, 0, r);
    send_req(KIND_UPDATE, 1000, 2, 64'h200, 1'b0, 0, r);
    send_req(KIND_UPDATE, 1000, 9, 64'h300, 1'b1, 0, r);
    send_req(KIND_UPDATE, 1000, 9, 64'h400, 1'b0, 0, r);
    send_req(KIND_UPDATE, 1000, 9, 64'h10400, 1'b0, 0, r);
    send_req(KIND_VICTIM, 1000, 0, '0, 1'b0, 0, r);
    send_req(KIND_UPDATE, 1500, 6, 64'h7000, 1'b1, 0, r);
    send_req(KIND_UPDATE, 1500, 6, 64'h9000, 1'b0, 0, r);
    send_req(KIND_VICTIM, 1500, 0, '0, 1'b0, 0, r);
  endtask

  task automatic test_random(input int n);
    int start;
    start = beats_sent;
    while (beats_sent - start < n) random_access();
  endtask

  // drive the selector down to its floor with BRRIP leader hits
  task automatic test_selector_sweep();
    rsp_beat_t r;
    int        s;
    int        extra;
    extra = 0;
    while (extra < 30) begin
      if (sel_m == '0) extra++;
      s = $urandom_range(NSETS - LEADERS, NSETS - 1);
      if ($urandom_range(0, 7) == 0) random_access();
      else send_req(KIND_UPDATE, s, $urandom_range(0, NWAYS - 1), next_addr(s), 1'b1,
                    pick_draw(), r);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_VICTIM;
    req_ch.set_index    = '0;
    req_ch.way_index    = '0;
    req_ch.phys_address = '0;
    req_ch.was_hit      = 1'b0;
    req_ch.random_draw  = '0;
    foreach (age_m[i, j]) age_m[i][j] = RRPV_MAX;
    foreach (reuse_m[i]) begin
      reuse_m[i]      = '0;
      conf_m[i]       = '0;
      last_addr_m[i]  = '0;
      last_delta_m[i] = '0;
    end
    sel_m       = SEL_MID;
    decay_cnt_m = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(280);
    test_selector_sweep();
    test_random(280);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (rrip_rsp_q.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("%0d beats (%0d victim searches, %0d streaming flags) in %0d cycles",
             beats_sent, victims_seen, stream_flags, cycle_cnt);
    $display("selector held at top %0d and bottom %0d times; %0d reuse decay sweeps",
             sel_top_hits, sel_low_hits, decay_wraps);
    if (err_cnt == 0) begin
      $display("PASS drrip_dead_block_stream_bypass");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL drrip_dead_block_stream_bypass");
    end
    $finish;
  end

endmodule
